### hw/rtl/drns_pkg.sv
// ----------------------------------------------------------------------------
// Directional rectangle neighbor search package
// Shared constants, request and response types for the search unit.
// ----------------------------------------------------------------------------
package drns_pkg;

  // Table geometry.
  localparam int unsigned MAX_WINDOWS = 32;
  localparam int unsigned IDX_W       = $clog2(MAX_WINDOWS);
  localparam int unsigned CNT_W       = $clog2(MAX_WINDOWS + 1);
  localparam int unsigned CRD_W       = 16;

  // Request operations. The fourth code has no meaning and is dropped.
  typedef enum logic [1:0] {
    OP_WRITE     = 2'd0,
    OP_NEIGHBOUR = 2'd1,
    OP_POINT     = 2'd2
  } opcode_e;

  // Search directions.
  typedef enum logic [1:0] {
    DIR_LEFT  = 2'd0,
    DIR_RIGHT = 2'd1,
    DIR_UP    = 2'd2,
    DIR_DOWN  = 2'd3
  } direction_e;

  // One stored rectangle.
  typedef struct packed {
    logic signed [CRD_W-1:0] x;
    logic signed [CRD_W-1:0] y;
    logic        [CRD_W-1:0] w;
    logic        [CRD_W-1:0] h;
  } rect_t;

  // Input request.
  typedef struct packed {
    logic        [1:0]       opcode;
    logic        [4:0]       slot;
    logic signed [CRD_W-1:0] rect_x;
    logic signed [CRD_W-1:0] rect_y;
    logic        [CRD_W-1:0] rect_width;
    logic        [CRD_W-1:0] rect_height;
    logic        [1:0]       direction;
    logic        [5:0]       window_count;
    logic signed [CRD_W-1:0] point_x;
    logic signed [CRD_W-1:0] point_y;
  } in_req_t;

  // Output response.
  typedef struct packed {
    logic       found;
    logic [4:0] window_index;
  } out_rsp_t;

endpackage

### hw/rtl/directional_rect_neighbour_search_unit.sv
// ----------------------------------------------------------------------------
// Directional rectangle neighbor search unit
// Rectangle table with a sequenced scan for directional neighbor and point
// hit queries.
// ----------------------------------------------------------------------------
// A write request stores one rectangle and returns nothing. The
// table has a single read port, so a query reads one entry per cycle and
// feeds it through a three-stage compare unit shared by both query kinds. A
// neighbor query first reads its source entry, then scans the live entries;
// a source at or beyond the count answers without a scan. A point query
// scans the live entries. A response still held by the output stall delays
// the next one.
// The input is stalled while a query runs. Entries must be written before a
// query reads them.
module directional_rect_neighbour_search_unit (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  drns_pkg::in_req_t  in_req_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output drns_pkg::out_rsp_t out_rsp_o
);

  typedef enum logic [3:0] {
    ST_IDLE   = 4'b0001,
    ST_SRC    = 4'b0010,
    ST_SCAN   = 4'b0100,
    ST_FINISH = 4'b1000
  } state_e;

  localparam int unsigned IW = drns_pkg::IDX_W;
  localparam int unsigned CW = drns_pkg::CNT_W;

  state_e state_q, state_d;

  // Query context.
  logic [1:0]           op_q;
  logic [1:0]           dir_q;
  logic [IW-1:0]        src_q;
  logic [CW-1:0]        n_q;
  logic signed [15:0]   px_q, py_q;
  logic                 axis_x_q;

  // Scan and pipeline control.
  logic [CW-1:0]        iss_q;
  logic                 vr_q, vs1_q, vs2_q;
  logic [IW-1:0]        ir_q, i1_q, i2_q;

  // Table and its read data.
  drns_pkg::rect_t      rect_mem_q [drns_pkg::MAX_WINDOWS];
  drns_pkg::rect_t      rd_data_q;
  logic [IW-1:0]        rd_addr;

  // Stage 1 edges of the candidate, and the same for the source.
  logic signed [17:0]   b_alo, b_aend, b_plo, b_phi;
  logic signed [18:0]   b_cen;
  logic signed [17:0]   b_alo_q, b_aend_q, b_plo_q, b_phi_q;
  logic signed [18:0]   b_cen_q;
  logic signed [17:0]   a_alo_q, a_aend_q, a_plo_q, a_phi_q;
  logic signed [18:0]   a_cen_q;

  // Stage 2 metrics.
  logic signed [17:0]   gap, lo, hi, span;
  logic signed [18:0]   cdiff;
  logic signed [17:0]   px_ext, py_ext;
  logic                 keep;
  logic [15:0]          ov;
  logic [17:0]          coff;
  logic                 keep2_q;
  logic [15:0]          d2_q, ov2_q;
  logic [17:0]          c2_q;

  // Best candidate so far.
  logic                 best_valid_q;
  logic [IW-1:0]        best_idx_q;
  logic [15:0]          bd_q, bo_q;
  logic [17:0]          bc_q;
  logic                 better;

  logic                 out_valid_q;
  drns_pkg::out_rsp_t   out_rsp_q;

  logic                 in_acc, mem_we, is_nbr, issue, rd_keep, scan_done, out_free;
  logic [CW-1:0]        n_sat;
  logic                 axis_x_in;

  assign in_stall_o = (state_q != ST_IDLE);
  assign in_acc     = in_valid_i && !in_stall_o;
  assign mem_we     = in_acc && (in_req_i.opcode == drns_pkg::OP_WRITE);
  assign n_sat      = (in_req_i.window_count > CW'(drns_pkg::MAX_WINDOWS)) ?
                      CW'(drns_pkg::MAX_WINDOWS) : in_req_i.window_count;
  assign axis_x_in  = (in_req_i.opcode == drns_pkg::OP_POINT) ||
                      (in_req_i.direction == drns_pkg::DIR_LEFT) ||
                      (in_req_i.direction == drns_pkg::DIR_RIGHT);
  assign is_nbr     = (op_q == drns_pkg::OP_NEIGHBOUR);
  assign issue      = (state_q == ST_SCAN) && (iss_q < n_q);
  assign rd_keep    = issue && !(is_nbr && (iss_q == {1'b0, src_q}));
  assign scan_done  = (state_q == ST_SCAN) && !issue && !vr_q && !vs1_q && !vs2_q;
  assign out_free   = !out_valid_q || !out_stall_i;
  assign rd_addr    = (state_q == ST_IDLE) ? in_req_i.slot : iss_q[IW-1:0];

  // Table: one write port, one registered read port.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      rect_mem_q[in_req_i.slot] <= '{x: in_req_i.rect_x, y: in_req_i.rect_y,
                                     w: in_req_i.rect_width, h: in_req_i.rect_height};
    end
    rd_data_q <= rect_mem_q[rd_addr];
  end

  // Sequencer.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          priority if (in_req_i.opcode == drns_pkg::OP_NEIGHBOUR) begin
            state_d = ({1'b0, in_req_i.slot} >= n_sat) ? ST_FINISH : ST_SRC;
          end else if (in_req_i.opcode == drns_pkg::OP_POINT) begin
            state_d = ST_SCAN;
          end else begin
            state_d = ST_IDLE;
          end
        end
      end
      ST_SRC:    state_d = ST_SCAN;
      ST_SCAN:   if (scan_done) state_d = ST_FINISH;
      ST_FINISH: if (out_free) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // Stage 1: edges along the search axis and across it, plus doubled center.
  always_comb begin
    logic [15:0] alen, plen;
    alen  = axis_x_q ? rd_data_q.w : rd_data_q.h;
    plen  = axis_x_q ? rd_data_q.h : rd_data_q.w;
    b_alo = axis_x_q ? 18'(rd_data_q.x) : 18'(rd_data_q.y);
    b_plo = axis_x_q ? 18'(rd_data_q.y) : 18'(rd_data_q.x);
    b_aend = b_alo + $signed({2'b00, alen});
    b_phi  = b_plo + $signed({2'b00, plen});
    b_cen  = $signed({b_plo, 1'b0}) + $signed({3'b000, plen});
  end

  // Stage 2: gap, shared span, center offset and point containment.
  always_comb begin
    if ((dir_q == drns_pkg::DIR_LEFT) || (dir_q == drns_pkg::DIR_UP)) begin
      gap = a_alo_q - b_aend_q;
    end else begin
      gap = b_alo_q - a_aend_q;
    end
    lo    = (a_plo_q > b_plo_q) ? a_plo_q : b_plo_q;
    hi    = (a_phi_q < b_phi_q) ? a_phi_q : b_phi_q;
    span  = hi - lo;
    ov    = (hi > lo) ? span[15:0] : 16'd0;
    cdiff = a_cen_q - b_cen_q;
    coff  = cdiff[18] ? 18'(-cdiff) : cdiff[17:0];
    px_ext = 18'(px_q);
    py_ext = 18'(py_q);
    if (is_nbr) begin
      keep = !gap[17];
    end else begin
      keep = (px_ext >= b_alo_q) && (px_ext < b_aend_q) &&
             (py_ext >= b_plo_q) && (py_ext < b_phi_q);
    end
  end

  // Stage 3: rank the candidate against the best so far.
  always_comb begin
    priority if (!best_valid_q) begin
      better = 1'b1;
    end else if (!is_nbr) begin
      better = 1'b0;
    end else if ((ov2_q != 16'd0) != (bo_q != 16'd0)) begin
      better = (ov2_q != 16'd0);
    end else if (d2_q != bd_q) begin
      better = (d2_q < bd_q);
    end else if (ov2_q != bo_q) begin
      better = (ov2_q > bo_q);
    end else begin
      better = (c2_q < bc_q);
    end
  end

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      iss_q        <= '0;
      vr_q         <= 1'b0;
      vs1_q        <= 1'b0;
      vs2_q        <= 1'b0;
      best_valid_q <= 1'b0;
      out_valid_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      vr_q    <= rd_keep;
      vs1_q   <= vr_q;
      vs2_q   <= vs1_q;
      if (in_acc) begin
        iss_q <= '0;
      end else if (issue) begin
        iss_q <= iss_q + CW'(1);
      end
      if (in_acc) begin
        best_valid_q <= 1'b0;
      end else if (vs2_q && keep2_q && better) begin
        best_valid_q <= 1'b1;
      end
      if ((state_q == ST_FINISH) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      op_q     <= in_req_i.opcode;
      dir_q    <= in_req_i.direction;
      src_q    <= in_req_i.slot;
      n_q      <= n_sat;
      px_q     <= in_req_i.point_x;
      py_q     <= in_req_i.point_y;
      axis_x_q <= axis_x_in;
    end
    if (state_q == ST_SRC) begin
      a_alo_q  <= b_alo;
      a_aend_q <= b_aend;
      a_plo_q  <= b_plo;
      a_phi_q  <= b_phi;
      a_cen_q  <= b_cen;
    end
    ir_q     <= iss_q[IW-1:0];
    i1_q     <= ir_q;
    b_alo_q  <= b_alo;
    b_aend_q <= b_aend;
    b_plo_q  <= b_plo;
    b_phi_q  <= b_phi;
    b_cen_q  <= b_cen;
    i2_q     <= i1_q;
    keep2_q  <= keep;
    d2_q     <= gap[15:0];
    ov2_q    <= ov;
    c2_q     <= coff;
    if (vs2_q && keep2_q && better) begin
      best_idx_q <= i2_q;
      bd_q       <= d2_q;
      bo_q       <= ov2_q;
      bc_q       <= c2_q;
    end
    if ((state_q == ST_FINISH) && out_free) begin
      out_rsp_q.found        <= best_valid_q;
      out_rsp_q.window_index <= best_valid_q ? best_idx_q : '0;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_rsp_q;

  // A response only appears after a query has reached its finish state.
  a_rsp_after_finish: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(state_q == ST_FINISH))
    else $error("response raised without a finished query");

  // A miss always reports index zero.
  a_miss_index_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !out_rsp_o.found) |-> (out_rsp_o.window_index == '0))
    else $error("miss response with nonzero index");

  // The scan never runs past the live entry count.
  a_scan_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SCAN) |-> (iss_q <= n_q))
    else $error("scan index beyond live count");

  // The chosen entry is always a live one.
  a_best_live: assert property (@(posedge clk_i) disable iff (!rst_ni)
    best_valid_q |-> ({1'b0, best_idx_q} < n_q))
    else $error("best entry outside live range");

endmodule
